>>> src/sprite_evaluation_engine_defines.svh
// Assertion helpers used by the checker.
`ifndef SPRITE_EVALUATION_ENGINE_DEFINES_SVH
`define SPRITE_EVALUATION_ENGINE_DEFINES_SVH

// same-cycle implication
`define SEE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("see: same-cycle check failed");

// next-cycle implication
`define SEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("see: next-cycle check failed");

`endif

>>> src/see_pkg.sv
`default_nettype none
package see_pkg;

    localparam int TABLE_BYTES = 256;
    localparam int SLOT_BYTES  = 32;
    localparam int SLOT_COUNT  = SLOT_BYTES / 4;
    localparam int CLEAR_DOTS  = 64;
    localparam int LAST_DOT    = 256;

    localparam int TADDR_W = $clog2(TABLE_BYTES);
    localparam int SADDR_W = $clog2(SLOT_BYTES);
    localparam int SIDX_W  = SADDR_W - 2;
    localparam int PTR_W   = 9;
    localparam int FILL_W  = 6;
    localparam int DOT_W   = 9;

    typedef logic [7:0] t_byte;

    localparam t_byte EMPTY_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        REQ_EVAL     = 2'd0,
        REQ_TABLE_WR = 2'd1,
        REQ_SLOT_RD  = 2'd2,
        REQ_CLR_OVF  = 2'd3
    } t_req;

    // (line - y) mod 256 below the sprite height
    function automatic logic y_in_range(input t_byte y, input t_byte line, input logic tall);
        t_byte diff;
        diff = line - y;
        return (diff[7:4] == 4'd0) && (tall || !diff[3]);
    endfunction

endpackage
`default_nettype wire

>>> src/see_if.sv
`default_nettype none
interface see_item_if;
    import see_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [8:0] dot;
    logic [7:0] scanline;
    logic [7:0] table_addr;
    logic [7:0] table_data;
    logic [4:0] slot_byte;

    modport source (output valid, req_type, dot, scanline, table_addr, table_data, slot_byte,
                    input ready);
    modport sink   (input valid, req_type, dot, scanline, table_addr, table_data, slot_byte,
                    output ready);
endinterface

interface see_result_if;
    import see_pkg::*;

    logic  valid;
    logic  ready;
    t_byte read_byte;
    t_byte sprite_number;
    logic  overflow;
    logic  scan_done;

    modport source (output valid, read_byte, sprite_number, overflow, scan_done,
                    input ready);
    modport sink   (input valid, read_byte, sprite_number, overflow, scan_done,
                    output ready);
endinterface
`default_nettype wire

>>> src/see_ram.sv
`default_nettype none
module see_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/sprite_evaluation_engine.sv
// Sprite evaluation engine: one item per clock when the result side keeps up.
// The result beat is valid in the cycle after the input beat is taken.
// Throughput: 1 item/cycle if not stalled; one read-modify-write of state per beat.
// Reset (synchronous, i_rst_n low): pointers, overflow, slot numbers and store valid
// bits clear at once; no clearing pass. Primary table is not cleared.
`default_nettype none
module sprite_evaluation_engine (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    see_item_if.sink   i_item,
    see_result_if.source o_result
);
    import see_pkg::*;

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]  r_scan, n_scan;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_ovf, n_ovf;
    logic              r_tall;
    // byte latch: either a constant (reset / dot 1) or the primary table read data
    logic              r_lsel, n_lsel;
    t_byte             r_lconst, n_lconst;
    t_byte             r_slot_num [SLOT_COUNT];
    t_byte             n_slot_num [SLOT_COUNT];
    // secondary store valid bits reset to zero: an entry reads zero until first written
    logic [SLOT_BYTES-1:0] r_sec_vld;

    // output stage
    logic  r_out_valid;
    logic  r_res_rd;
    logic  r_res_vld;
    t_byte r_res_snum;
    logic  r_res_ovf;
    logic  r_res_done;

    logic w_acc;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_acc        = i_item.valid && i_item.ready;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic               pri_we, pri_re;
    logic [TADDR_W-1:0] pri_waddr, pri_raddr;
    t_byte              pri_q;

    logic               sec_we, sec_re;
    logic [SADDR_W-1:0] sec_waddr, sec_raddr;
    t_byte              sec_wdata, sec_q;

    see_ram #(.DEPTH(TABLE_BYTES), .WIDTH(8)) u_primary (
        .i_clk   (i_clk),
        .i_we    (pri_we),
        .i_waddr (pri_waddr),
        .i_wdata (i_item.table_data),
        .i_re    (pri_re),
        .i_raddr (pri_raddr),
        .o_rdata (pri_q)
    );

    see_ram #(.DEPTH(SLOT_BYTES), .WIDTH(8)) u_secondary (
        .i_clk   (i_clk),
        .i_we    (sec_we),
        .i_waddr (sec_waddr),
        .i_wdata (sec_wdata),
        .i_re    (sec_re),
        .i_raddr (sec_raddr),
        .o_rdata (sec_q)
    );

    // ---------------------------------------------------------------
    // Evaluation step. An even dot is taken at least one beat after any
    // odd dot that read the table, so pri_q is ready by then.
    // ---------------------------------------------------------------
    t_byte            w_latch;
    logic [DOT_W-1:0] w_clr_idx;
    logic             w_inrange;
    logic             w_is_eval;
    logic             w_rd_ok;

    assign w_latch   = r_lsel ? pri_q : r_lconst;
    assign w_clr_idx = (i_item.dot >> 1) - DOT_W'(1);
    assign w_inrange = y_in_range(w_latch, i_item.scanline, r_tall);
    assign w_is_eval = w_acc && (i_item.req_type == REQ_EVAL);
    assign w_rd_ok   = {1'b0, i_item.slot_byte} < 6'(SLOT_BYTES);

    always_comb begin
        n_scan     = r_scan;
        n_fill     = r_fill;
        n_ovf      = r_ovf;
        n_lsel     = r_lsel;
        n_lconst   = r_lconst;
        n_slot_num = r_slot_num;
        sec_we     = 1'b0;
        sec_waddr  = r_fill[SADDR_W-1:0];
        sec_wdata  = w_latch;
        pri_re     = 1'b0;
        pri_raddr  = r_scan[TADDR_W-1:0];

        if (w_is_eval && i_item.dot != '0 && i_item.dot <= DOT_W'(LAST_DOT)) begin
            if (i_item.dot <= DOT_W'(CLEAR_DOTS)) begin
                if (i_item.dot == DOT_W'(1)) begin
                    n_scan   = '0;
                    n_fill   = '0;
                    n_lsel   = 1'b0;
                    n_lconst = EMPTY_BYTE;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        n_slot_num[i] = EMPTY_BYTE;
                    end
                end else if (!i_item.dot[0] && w_clr_idx < DOT_W'(SLOT_BYTES)) begin
                    sec_we    = 1'b1;
                    sec_waddr = w_clr_idx[SADDR_W-1:0];
                    sec_wdata = EMPTY_BYTE;
                end
            end else if (r_scan < PTR_W'(TABLE_BYTES)) begin
                if (i_item.dot[0]) begin
                    pri_re = 1'b1;
                    n_lsel = 1'b1;
                end else if (r_fill < FILL_W'(SLOT_BYTES)) begin
                    sec_we = 1'b1;
                    if (r_scan[1:0] == 2'd0 && !w_inrange) begin
                        // skip the rest of this sprite
                        n_scan = r_scan + PTR_W'(4);
                    end else begin
                        if (r_scan[1:0] == 2'd0) begin
                            n_slot_num[r_fill[SADDR_W-1:2]] = 8'(r_scan >> 2);
                        end
                        n_fill = r_fill + FILL_W'(1);
                        n_scan = r_scan + PTR_W'(1);
                    end
                end else if (w_inrange) begin
                    n_ovf  = 1'b1;
                    n_scan = PTR_W'(TABLE_BYTES);
                end else begin
                    // slots full: sprite and byte index both step (diagonal walk)
                    n_scan = {r_scan[PTR_W-1:2] + (PTR_W-2)'(1), r_scan[1:0] + 2'd1};
                end
            end
        end else if (w_acc && i_item.req_type == REQ_CLR_OVF) begin
            n_ovf = 1'b0;
        end
    end

    assign pri_we    = w_acc && (i_item.req_type == REQ_TABLE_WR)
                       && (PTR_W'(i_item.table_addr) < PTR_W'(TABLE_BYTES));
    assign pri_waddr = i_item.table_addr[TADDR_W-1:0];
    assign sec_re    = w_acc && (i_item.req_type == REQ_SLOT_RD);
    assign sec_raddr = i_item.slot_byte[SADDR_W-1:0];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_tall      <= 1'b0;
            r_lsel      <= 1'b0;
            r_lconst    <= '0;
            r_sec_vld   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_num[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tall <= i_cfg_wdata;
            end
            r_scan     <= n_scan;
            r_fill     <= n_fill;
            r_ovf      <= n_ovf;
            r_lsel     <= n_lsel;
            r_lconst   <= n_lconst;
            r_slot_num <= n_slot_num;
            if (sec_we) begin
                r_sec_vld[sec_waddr] <= 1'b1;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, captured with the input beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res_rd   <= sec_re && w_rd_ok;
            r_res_vld  <= r_sec_vld[sec_raddr];
            r_res_ovf  <= n_ovf;
            r_res_done <= n_scan >= PTR_W'(TABLE_BYTES);
            if (!sec_re) begin
                r_res_snum <= '0;
            end else if (w_rd_ok) begin
                r_res_snum <= r_slot_num[i_item.slot_byte[SADDR_W-1:2]];
            end else begin
                r_res_snum <= EMPTY_BYTE;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.read_byte     = (r_res_rd && r_res_vld) ? sec_q : '0;
    assign o_result.sprite_number = r_res_snum;
    assign o_result.overflow      = r_res_ovf;
    assign o_result.scan_done     = r_res_done;

endmodule
`default_nettype wire

>>> src/see_checker.sv
`default_nettype none
`include "sprite_evaluation_engine_defines.svh"
module see_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_req_type,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_read_byte,
    input wire logic [7:0] i_sprite_number,
    input wire logic       i_overflow
);
    import see_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // every beat taken shows its result on the next cycle
    `SEE_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_acc, i_out_valid)
    // a stalled result blocks intake
    `SEE_ASSERT_SAME(a_stall_blocks, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    // only slot reads return data
    `SEE_ASSERT_NEXT(a_nonread_zero, i_clk, i_rst_n, in_acc && i_req_type != REQ_SLOT_RD,
        i_read_byte == 8'd0 && i_sprite_number == 8'd0)
    // clearing overflow reports it clear
    `SEE_ASSERT_NEXT(a_clear_ovf, i_clk, i_rst_n, in_acc && i_req_type == REQ_CLR_OVF,
        !i_overflow)
    `SEE_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_read_byte) && $stable(i_sprite_number))

endmodule

bind sprite_evaluation_engine see_checker u_see_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_req_type      (i_item.req_type),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_read_byte     (o_result.read_byte),
    .i_sprite_number (o_result.sprite_number),
    .i_overflow      (o_result.overflow)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import see_pkg::*;

    // One request beat as the testbench sees it.
    typedef struct packed {
        t_req       kind;
        logic [8:0] dot;
        t_byte      line;
        t_byte      taddr;
        t_byte      tdata;
        logic [4:0] sbyte;
    } t_sprite_req;

    // One status beat: slot readout plus the two flags.
    typedef struct packed {
        t_byte rd_byte;
        t_byte owner;
        logic  ovf;
        logic  done;
    } t_eval_status;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;

    see_item_if   item_bus ();
    see_result_if result_bus ();

    sprite_evaluation_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the evaluator state
    // ------------------------------------------------------------------
    t_byte      sprite_table [TABLE_BYTES];
    t_byte      slot_mem     [SLOT_BYTES];
    t_byte      slot_owner   [SLOT_COUNT];
    logic [8:0] scan_ptr = '0;
    t_byte      latch_q  = '0;
    logic [5:0] fill_ptr = '0;
    logic       ovf_q    = 1'b0;
    logic       tall_q   = 1'b0;

    t_sprite_req  req_backlog [$];   // requests not yet driven
    t_eval_status status_due  [$];   // status beats owed by the block
    t_sprite_req  cur_req;           // request currently on the bus
    t_eval_status due;

    int  mismatches = 0;
    int  send_gap   = 0;
    int  stall_gap  = 0;
    bit  quiet      = 1'b0;          // no idling on either side when set

    // Sprite row test: distance from Y to the line, modulo 256, below the height.
    // A Y just above the line wraps to a large distance and misses.
    function automatic logic sprite_on_line(input t_byte y, input t_byte line);
        t_byte dist_rows;
        dist_rows = line - y;
        return dist_rows < (tall_q ? 8'd16 : 8'd8);
    endfunction

    // Applies one accepted request to the shadow state and returns the
    // status beat the block must send for it.
    function automatic t_eval_status sprite_eval_step(input t_sprite_req r);
        t_eval_status res;
        int unsigned  idx;
        logic [1:0]   lane;
        res = '0;
        case (r.kind)
            REQ_EVAL: begin
                // dot 0 and dots past the line end are ignored
                if (r.dot >= 1 && r.dot <= LAST_DOT) begin
                    if (r.dot <= CLEAR_DOTS) begin
                        // clear phase: dot 1 rewinds, even dots blank one store byte
                        if (r.dot == 1) begin
                            scan_ptr = '0;
                            latch_q  = EMPTY_BYTE;
                            fill_ptr = '0;
                            foreach (slot_owner[k]) slot_owner[k] = EMPTY_BYTE;
                        end else if (!r.dot[0]) begin
                            idx = r.dot / 2 - 1;
                            if (idx < SLOT_BYTES) slot_mem[SADDR_W'(idx)] = EMPTY_BYTE;
                        end
                    end else if (scan_ptr < TABLE_BYTES) begin
                        if (r.dot[0]) begin
                            // odd dot: fetch one table byte
                            latch_q = sprite_table[scan_ptr[TADDR_W-1:0]];
                        end else begin
                            lane = scan_ptr[1:0];
                            if (fill_ptr < SLOT_BYTES) begin
                                slot_mem[fill_ptr[SADDR_W-1:0]] = latch_q;
                                if (lane != 2'd0) begin
                                    fill_ptr++;
                                    scan_ptr++;
                                end else if (sprite_on_line(latch_q, r.line)) begin
                                    slot_owner[fill_ptr[SADDR_W-1:2]] = t_byte'(scan_ptr >> 2);
                                    fill_ptr++;
                                    scan_ptr++;
                                end else begin
                                    scan_ptr += 9'd4;
                                end
                            end else if (sprite_on_line(latch_q, r.line)) begin
                                // slots full and a hit: overflow, scan ends
                                ovf_q    = 1'b1;
                                scan_ptr = 9'(TABLE_BYTES);
                            end else begin
                                // slots full: sprite and byte index both step (diagonal walk)
                                scan_ptr = {scan_ptr[8:2] + 7'd1, lane + 2'd1};
                            end
                        end
                    end
                end
            end
            REQ_TABLE_WR: begin
                if (r.taddr < TABLE_BYTES) sprite_table[r.taddr] = r.tdata;
            end
            REQ_SLOT_RD: begin
                if (r.sbyte < SLOT_BYTES) begin
                    res.rd_byte = slot_mem[r.sbyte];
                    res.owner   = slot_owner[r.sbyte[SADDR_W-1:2]];
                end else begin
                    res.owner = EMPTY_BYTE;
                end
            end
            REQ_CLR_OVF: begin
                ovf_q = 1'b0;
            end
        endcase
        res.ovf  = ovf_q;
        res.done = (scan_ptr >= TABLE_BYTES);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders; fields the operation ignores get random values
    // ------------------------------------------------------------------
    function automatic t_sprite_req any_request();
        t_sprite_req r;
        r.kind  = t_req'($urandom_range(0, 3));
        r.dot   = 9'($urandom_range(0, 511));
        r.line  = t_byte'($urandom);
        r.taddr = t_byte'($urandom);
        r.tdata = t_byte'($urandom);
        r.sbyte = 5'($urandom);
        return r;
    endfunction

    task automatic push_eval(input int dot, input int line);
        t_sprite_req r;
        r      = any_request();
        r.kind = REQ_EVAL;
        r.dot  = 9'(dot);
        r.line = t_byte'(line);
        req_backlog.push_back(r);
    endtask

    task automatic push_write(input int addr, input int data);
        t_sprite_req r;
        r       = any_request();
        r.kind  = REQ_TABLE_WR;
        r.taddr = t_byte'(addr);
        r.tdata = t_byte'(data);
        req_backlog.push_back(r);
    endtask

    task automatic push_read(input int sbyte);
        t_sprite_req r;
        r       = any_request();
        r.kind  = REQ_SLOT_RD;
        r.sbyte = 5'(sbyte);
        req_backlog.push_back(r);
    endtask

    task automatic push_clear();
        t_sprite_req r;
        r      = any_request();
        r.kind = REQ_CLR_OVF;
        req_backlog.push_back(r);
    endtask

    // One scanline: rewrite some sprite Y bytes so that 'hits' of them land on
    // the line (the others usually miss, many just above it so the row test wraps), then
    // the dot sequence with stray requests mixed in and the odd dot dropped,
    // then a readout of the slots.
    task automatic queue_scanline(input t_byte line, input int hits, input int last_dot);
        int    height;
        int    i;
        int    d;
        t_byte y;
        height = tall_q ? 16 : 8;
        for (i = 0; i < 24; i++) begin
            if (i < hits)
                y = line - t_byte'($urandom_range(0, height - 1));
            else if ($urandom_range(0, 1) == 1)
                y = line + t_byte'($urandom_range(1, 16));
            else
                y = t_byte'($urandom);
            push_write(4 * $urandom_range(0, 63), y);
        end
        for (d = 1; d <= last_dot; d++) begin
            if ($urandom_range(0, 23) == 0) req_backlog.push_back(any_request());
            if ($urandom_range(0, 63) != 0) push_eval(d, line);
        end
        for (i = 0; i < 8; i++) push_read($urandom_range(0, SLOT_BYTES - 1));
        if ($urandom_range(0, 1) == 1) push_clear();
    endtask

    // Register write, only once every request has been answered.
    task automatic set_tall_sprites(input logic v);
        while (req_backlog.size() != 0 || item_bus.valid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        tall_q       = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: one request beat per handshake, random idle bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            send_gap       <= 0;
        end else begin
            if (item_bus.valid && item_bus.ready)
                status_due.push_back(sprite_eval_step(cur_req));

            if (item_bus.valid && !item_bus.ready) begin
                // beat not taken yet: hold everything
            end else if (send_gap != 0) begin
                item_bus.valid <= 1'b0;
                send_gap       <= send_gap - 1;
            end else if (req_backlog.size() != 0 && !quiet && $urandom_range(0, 15) == 0) begin
                // idle burst
                item_bus.valid <= 1'b0;
                send_gap       <= $urandom_range(0, 9);
            end else if (req_backlog.size() != 0) begin
                cur_req = req_backlog.pop_front();
                item_bus.valid      <= 1'b1;
                item_bus.req_type   <= cur_req.kind;
                item_bus.dot        <= cur_req.dot;
                item_bus.scanline   <= cur_req.line;
                item_bus.table_addr <= cur_req.taddr;
                item_bus.table_data <= cur_req.tdata;
                item_bus.slot_byte  <= cur_req.sbyte;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each status beat with the oldest prediction,
    // throttle ready in random bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            stall_gap        <= 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (status_due.size() == 0) begin
                    $error("status beat arrived with nothing expected");
                    mismatches++;
                end else begin
                    due = status_due.pop_front();
                    if (result_bus.read_byte !== due.rd_byte) begin
                        $error("read_byte: expected %0h, actual %0h",
                               due.rd_byte, result_bus.read_byte);
                        mismatches++;
                    end
                    if (result_bus.sprite_number !== due.owner) begin
                        $error("sprite_number: expected %0h, actual %0h",
                               due.owner, result_bus.sprite_number);
                        mismatches++;
                    end
                    if (result_bus.overflow !== due.ovf) begin
                        $error("overflow: expected %0b, actual %0b",
                               due.ovf, result_bus.overflow);
                        mismatches++;
                    end
                    if (result_bus.scan_done !== due.done) begin
                        $error("scan_done: expected %0b, actual %0b",
                               due.done, result_bus.scan_done);
                        mismatches++;
                    end
                end
            end

            if (stall_gap != 0) begin
                result_bus.ready <= 1'b0;
                stall_gap        <= stall_gap - 1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                // stall burst
                result_bus.ready <= 1'b0;
                stall_gap        <= $urandom_range(0, 9);
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int i;
        int line;
        int hits;
        int last_dot;

        item_bus.valid      = 1'b0;
        item_bus.req_type   = REQ_EVAL;
        item_bus.dot        = '0;
        item_bus.scanline   = '0;
        item_bus.table_addr = '0;
        item_bus.table_data = '0;
        item_bus.slot_byte  = '0;
        result_bus.ready    = 1'b0;
        foreach (slot_mem[k]) slot_mem[k] = '0;
        foreach (slot_owner[k]) slot_owner[k] = '0;
        foreach (sprite_table[k]) sprite_table[k] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_tall_sprites(1'b0);

        // Directed: reset contents, ignored dots, a scan step before any
        // clear, the line-start rewind and the clear of both store ends.
        push_read(0);
        push_read(SLOT_BYTES - 1);
        push_clear();
        push_eval(0, 0);
        push_eval(257, 0);
        push_eval(511, 255);
        push_write(0, 8'h00);
        push_write(TABLE_BYTES - 1, 8'hFF);
        push_eval(65, 0);
        push_eval(66, 0);
        push_read(0);
        push_eval(1, 0);
        push_read(0);
        push_eval(2, 0);
        push_eval(64, 0);
        push_read(0);
        push_read(SLOT_BYTES - 1);
        push_eval(65, 0);

        // Fill the whole table before any scan can reach an unwritten byte.
        for (i = 0; i < TABLE_BYTES; i++) push_write(i, $urandom_range(0, 255));

        // Lines alternate sprite height; even phases crowd the line so the
        // slots fill and the overflow walk runs, odd phases may stop early.
        for (phase = 0; phase < 4; phase++) begin
            set_tall_sprites(phase % 2 == 0);
            if (phase == 3) quiet = 1'b1;
            line     = (phase == 0) ? 0 : (phase == 1) ? 255 : $urandom_range(0, 255);
            hits     = (phase % 2 == 0) ? $urandom_range(9, 20) : $urandom_range(0, 12);
            last_dot = (phase % 2 == 1 && $urandom_range(0, 2) == 0) ?
                       $urandom_range(65, 255) : LAST_DOT;
            queue_scanline(t_byte'(line), hits, last_dot);
            if (phase == 0) begin
                for (i = 0; i < SLOT_BYTES; i++) push_read(i);
            end
        end

        while (req_backlog.size() != 0 || item_bus.valid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sprite_evaluation_engine.f
+incdir+src
src/see_pkg.sv
src/see_if.sv
src/see_ram.sv
src/sprite_evaluation_engine.sv
src/see_checker.sv
tb/tb.sv
